@@ rtl/core/blpt_pkg.sv @@
// ----------------------------------------------------------------------------
// blpt_pkg
// shared types and constants of the button long-press and multi-click unit
// ----------------------------------------------------------------------------
package blpt_pkg;

   // field widths
   localparam int unsigned PIN_W   = 5;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TIME_W  = 63;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned CSR_IDX_W = 2;

   // default pin count of the gpio words
   localparam int unsigned PIN_COUNT_DEF = 32;

   // register reset values
   localparam logic [PIN_W-1:0]   WATCHED_PIN_RST     = '0;
   localparam logic [WORD_W-1:0]  LONG_PRESS_US_RST   = 32'd5000000;
   localparam logic [WORD_W-1:0]  CLICK_WINDOW_US_RST = 32'd3000000;
   localparam logic [COUNT_W-1:0] CLICKS_NEEDED_RST   = 4'd3;

   // saturation value of the click count
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHED_PIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_US   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_WINDOW_US = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICKS_NEEDED   = 2'd3;

   // one interrupt event
   typedef struct packed {
      logic [WORD_W-1:0] pending_mask;
      logic [WORD_W-1:0] level_word;
      logic [TIME_W-1:0] timestamp_us;
   } req_type;

   // one result
   typedef struct packed {
      logic [WORD_W-1:0] clear_mask;
      logic              long_press;
      logic              multi_click;
   } rsp_type;

   // configuration register set
   typedef struct packed {
      logic [PIN_W-1:0]   watched_pin;
      logic [WORD_W-1:0]  long_press_us;
      logic [WORD_W-1:0]  click_window_us;
      logic [COUNT_W-1:0] clicks_needed;
   } cfg_type;

endpackage

@@ rtl/core/blpt_detect.sv @@
// ----------------------------------------------------------------------------
// blpt_detect
// press state and single-pass evaluation of one interrupt event
// ----------------------------------------------------------------------------
module blpt_detect import blpt_pkg::*; #(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int unsigned DIFF_W = TIME_W + 1;

   logic               prev_level_ff, prev_level_in;
   logic [TIME_W-1:0]  press_start_ff, press_start_in;
   logic [TIME_W-1:0]  last_release_ff, last_release_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               pin_ok;
   logic               hit;
   logic               level;
   logic signed [DIFF_W-1:0] held;
   logic signed [DIFF_W-1:0] gap;
   logic               is_long;
   logic               in_window;
   logic [COUNT_W-1:0] count_step;

   // pin selection and signed time differences
   assign pin_ok = {1'b0, cfg.watched_pin} < (PIN_W+1)'(PIN_COUNT);
   assign hit    = pin_ok && item.pending_mask[cfg.watched_pin];
   assign level  = item.level_word[cfg.watched_pin];
   assign held   = $signed({1'b0, item.timestamp_us}) - $signed({1'b0, press_start_ff});
   assign gap    = $signed({1'b0, item.timestamp_us}) - $signed({1'b0, last_release_ff});

   // long press when held is non-negative and reaches the threshold
   assign is_long   = !held[DIFF_W-1] &&
                      (held[DIFF_W-2:0] >= (DIFF_W-1)'(cfg.long_press_us));
   // a negative gap counts as inside the window
   assign in_window = gap[DIFF_W-1] ||
                      (gap[DIFF_W-2:0] <= (DIFF_W-1)'(cfg.click_window_us));

   // saturating click count step
   always_comb begin
      if (!in_window) begin
         count_step = COUNT_W'(1);
      end else if (count_ff == COUNT_MAX) begin
         count_step = COUNT_MAX;
      end else begin
         count_step = count_ff + COUNT_W'(1);
      end
   end

   // edge handling and result
   always_comb begin
      prev_level_in      = prev_level_ff;
      press_start_in     = press_start_ff;
      last_release_in    = last_release_ff;
      count_in           = count_ff;
      result.clear_mask  = '0;
      result.long_press  = 1'b0;
      result.multi_click = 1'b0;
      if (hit) begin
         result.clear_mask = WORD_W'(1) << cfg.watched_pin;
         prev_level_in     = level;
         if (!level && prev_level_ff) begin
            press_start_in = item.timestamp_us;
         end else if (level && !prev_level_ff) begin
            if (is_long) begin
               result.long_press = 1'b1;
               count_in          = '0;
            end else begin
               last_release_in = item.timestamp_us;
               if (count_step >= cfg.clicks_needed) begin
                  result.multi_click = 1'b1;
                  count_in           = '0;
               end else begin
                  count_in = count_step;
               end
            end
         end
      end
   end

   // state registers, updated once per evaluated beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b1;
         press_start_ff  <= '0;
         last_release_ff <= '0;
         count_ff        <= '0;
      end else if (fire) begin
         prev_level_ff   <= prev_level_in;
         press_start_ff  <= press_start_in;
         last_release_ff <= last_release_in;
         count_ff        <= count_in;
      end
   end

endmodule

@@ rtl/core/button_long_press_triple_click_unit.sv @@
// ----------------------------------------------------------------------------
// button_long_press_triple_click_unit
// long-press and multi-click detection on gpio interrupt events
// ----------------------------------------------------------------------------
// Every request beat is one gpio interrupt event and gives exactly one
// response beat. The unit takes one beat per cycle while the request side
// does not stall. A request is captured in the input register when it is
// taken and is evaluated into the result register when that register is
// empty or its response is being taken. While a response is stalled and
// the input register is full, the request side stalls; the request side
// also stalls during reset. The press state is read and rewritten in the
// evaluation stage on each evaluated beat, so back-to-back events see each
// other's updates. Write the control registers only while no beat is in
// flight.
module button_long_press_triple_click_unit import blpt_pkg::*; #(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    advance;
   logic    take;
   logic    fire;

   // handshake
   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = reset || (in_vld_ff && !advance);
   assign take      = req_valid && !req_stall;
   assign fire      = in_vld_ff && advance;
   assign in_vld_in  = take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? in_vld_ff : out_vld_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WATCHED_PIN:     cfg_in.watched_pin     = csr_wdata[PIN_W-1:0];
            CSR_LONG_PRESS_US:   cfg_in.long_press_us   = csr_wdata;
            CSR_CLICK_WINDOW_US: cfg_in.click_window_us = csr_wdata;
            CSR_CLICKS_NEEDED:   cfg_in.clicks_needed   = csr_wdata[COUNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // control registers and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watched_pin     <= WATCHED_PIN_RST;
         cfg_ff.long_press_us   <= LONG_PRESS_US_RST;
         cfg_ff.click_window_us <= CLICK_WINDOW_US_RST;
         cfg_ff.clicks_needed   <= CLICKS_NEEDED_RST;
         in_vld_ff              <= 1'b0;
         out_vld_ff             <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   // evaluation stage
   blpt_detect #(
      .PIN_COUNT (PIN_COUNT)
   ) u_detect (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule
